### hdl/cpea_pkg.sv
package cpea_pkg;

	localparam logic [1:0] OP_VERTEX = 2'd0;
	localparam logic [1:0] OP_EDGE   = 2'd1;
	localparam logic [1:0] OP_PAIR   = 2'd2;
	localparam logic [1:0] OP_COMM   = 2'd3;

	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  ca;
		logic [7:0]  cb;
		logic [15:0] in_deg;
		logic [15:0] out_deg;
		logic [9:0]  idx;
	} cmd_t;

endpackage

### hdl/cpea_front.sv
module cpea_front
	import cpea_pkg::*;
#(
	parameter int COMMUNITIES = 256,
	parameter int DEGREE_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [7:0]  comm_a,
	input  logic [7:0]  comm_b,
	input  logic [15:0] in_degree,
	input  logic [15:0] out_degree,
	input  logic [9:0]  pair_index,
	output logic        q_valid,
	input  logic        q_ready,
	output cmd_t        q_cmd
);
	localparam int QD = 2;

	cmd_t       fifo_q [QD];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	cmd_t       c;
	logic [15:0] dmask;

	// community reduce: restoring remainder against shifted copies of the constant count
	function automatic logic [7:0] comm_reduce(input logic [7:0] v);
		logic [23:0] r;
		r = {16'd0, v};
		for (int i = 7; i >= 0; i--) begin
			if (r >= (24'(COMMUNITIES) << i)) r = r - (24'(COMMUNITIES) << i);
		end
		return r[7:0];
	endfunction

	always_comb begin
		dmask = (DEGREE_BITS >= 16) ? 16'hFFFF : 16'((17'd1 << DEGREE_BITS) - 17'd1);
		c.op      = op;
		c.ca      = comm_reduce(comm_a);
		c.cb      = comm_reduce(comm_b);
		c.in_deg  = in_degree & dmask;
		c.out_deg = out_degree & dmask;
		c.idx     = pair_index;
	end

	assign in_ready = (cnt_q != 2'(QD));
	assign q_valid  = (cnt_q != 2'd0);
	assign q_cmd    = fifo_q[rp_q];

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) fifo_q[wp_q] <= c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (in_valid && in_ready) wp_q <= ~wp_q;
			if (q_valid && q_ready) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(in_valid && in_ready) - 2'(q_valid && q_ready);
		end
	end

endmodule

### hdl/cpea_back.sv
module cpea_back
	import cpea_pkg::*;
#(
	parameter int PAIR_SLOTS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	output logic        q_ready,
	input  cmd_t        q_cmd,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [9:0]  pair_id,
	output logic [7:0]  pair_origin,
	output logic [7:0]  pair_target,
	output logic [23:0] pair_edges,
	output logic        is_new,
	output logic        skipped,
	output logic        table_full,
	output logic [23:0] members,
	output logic [31:0] total_in,
	output logic [31:0] total_out,
	output logic [23:0] cross_out,
	output logic [23:0] cross_in
);
	localparam int PW = (PAIR_SLOTS > 1) ? $clog2(PAIR_SLOTS) : 1;
	localparam int UW = $clog2(PAIR_SLOTS + 1);

	localparam logic [3:0] S_IDLE = 4'd0, S_RDA = 4'd1, S_UPA = 4'd2, S_RDB = 4'd3,
		S_UPB = 4'd4, S_SCAN = 4'd5, S_CHK = 4'd6, S_PUPD = 4'd7, S_FIN = 4'd8,
		S_OUT = 4'd9, S_PRD = 4'd10, S_PRD2 = 4'd11;

	// community totals, valid bits stand for the zero reset
	logic [23:0] mem_mc [256];
	logic [31:0] mem_in [256];
	logic [31:0] mem_out [256];
	logic [23:0] mem_lv [256];
	logic [23:0] mem_en [256];
	logic [255:0] cv_q;
	logic [7:0]  pf [PAIR_SLOTS];
	logic [7:0]  pt [PAIR_SLOTS];
	logic [23:0] pc [PAIR_SLOTS];

	logic [3:0]  st_q;
	cmd_t        cmd_q;
	logic [UW-1:0] used_q;
	logic [UW-1:0] k_q;
	logic [7:0]  caddr;
	logic        cwe;
	logic [23:0] r_mc, r_lv, r_en, w_mc, w_lv, w_en;
	logic [31:0] r_in, r_out, w_in, w_out;
	logic [7:0]  rf_q, rt_q;
	logic [23:0] rc_q;
	logic [PW-1:0] paddr;
	logic        pwe;
	logic [7:0]  pwf, pwt;
	logic [23:0] pwc;
	logic        found_q;

	function automatic logic [31:0] sat32(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	function automatic logic [23:0] inc24(input logic [23:0] a);
		return (a == 24'hFF_FFFF) ? a : a + 24'd1;
	endfunction

	always_comb begin
		caddr = (st_q == S_RDB || st_q == S_UPB) ? cmd_q.cb : cmd_q.ca;
		cwe = 1'b0;
		w_mc = r_mc; w_in = r_in; w_out = r_out; w_lv = r_lv; w_en = r_en;
		if (st_q == S_UPA) begin
			if (cmd_q.op == OP_VERTEX) begin
				cwe = 1'b1;
				w_mc = inc24(r_mc);
				w_in = sat32(r_in, {16'd0, cmd_q.in_deg});
				w_out = sat32(r_out, {16'd0, cmd_q.out_deg});
			end else if (cmd_q.op == OP_EDGE && cmd_q.ca != cmd_q.cb) begin
				cwe = 1'b1;
				w_lv = inc24(r_lv);
			end
		end else if (st_q == S_UPB) begin
			cwe = 1'b1;
			w_en = inc24(r_en);
		end
	end

	always_ff @(posedge clk) begin
		if (cwe) begin
			mem_mc[caddr] <= w_mc; mem_in[caddr] <= w_in; mem_out[caddr] <= w_out;
			mem_lv[caddr] <= w_lv; mem_en[caddr] <= w_en;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cv_q <= '0;
		else if (cwe) cv_q[caddr] <= 1'b1;
	end

	// registered read, masked by valid bit
	logic        rv_q;
	logic [23:0] m_mc, m_lv, m_en;
	logic [31:0] m_in, m_out;
	always_ff @(posedge clk) begin
		rv_q <= cv_q[caddr];
		m_mc <= mem_mc[caddr]; m_in <= mem_in[caddr]; m_out <= mem_out[caddr];
		m_lv <= mem_lv[caddr]; m_en <= mem_en[caddr];
	end
	assign r_mc = rv_q ? m_mc : '0;
	assign r_in = rv_q ? m_in : '0;
	assign r_out = rv_q ? m_out : '0;
	assign r_lv = rv_q ? m_lv : '0;
	assign r_en = rv_q ? m_en : '0;

	always_comb begin
		pwe = 1'b0; pwf = cmd_q.ca; pwt = cmd_q.cb; pwc = inc24(rc_q);
		paddr = PW'(k_q);
		if (st_q == S_PRD) paddr = PW'(cmd_q.idx);
		if (st_q == S_PUPD) begin
			pwe = 1'b1;
			if (!found_q) pwc = 24'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (pwe) begin
			pf[paddr] <= pwf; pt[paddr] <= pwt; pc[paddr] <= pwc;
		end
		rf_q <= pf[paddr]; rt_q <= pt[paddr]; rc_q <= pc[paddr];
	end

	assign q_ready = (st_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE; used_q <= '0; k_q <= '0; found_q <= 1'b0; out_valid <= 1'b0;
		end else begin
			unique case (st_q)
				S_IDLE: if (q_valid) begin
					cmd_q <= q_cmd;
					k_q <= '0; found_q <= 1'b0;
					pair_id <= '0; pair_origin <= '0; pair_target <= '0; pair_edges <= '0;
					is_new <= 1'b0; skipped <= 1'b0; table_full <= 1'b0;
					st_q <= (q_cmd.op == OP_PAIR) ? S_PRD : S_RDA;
				end
				S_RDA: st_q <= S_UPA;
				S_UPA: begin
					if (cmd_q.op == OP_EDGE && cmd_q.ca == cmd_q.cb) begin
						skipped <= 1'b1; st_q <= S_FIN;
					end else if (cmd_q.op == OP_EDGE) begin
						pair_origin <= cmd_q.ca; pair_target <= cmd_q.cb;
						st_q <= S_RDB;
					end else st_q <= S_FIN;
				end
				S_RDB: st_q <= S_UPB;
				S_UPB: st_q <= (used_q == '0) ? S_CHK : S_SCAN;
				S_SCAN: st_q <= S_CHK; // pair memory read of slot k
				S_CHK: begin
					if (k_q < used_q && rf_q == cmd_q.ca && rt_q == cmd_q.cb) begin
						found_q <= 1'b1; st_q <= S_PUPD;
					end else if (k_q + UW'(1) < used_q) begin
						k_q <= k_q + UW'(1); st_q <= S_SCAN;
					end else if (used_q >= UW'(PAIR_SLOTS)) begin
						table_full <= 1'b1; st_q <= S_FIN;
					end else begin
						k_q <= used_q; is_new <= 1'b1; st_q <= S_PUPD;
					end
				end
				S_PUPD: begin
					if (!found_q) used_q <= used_q + UW'(1);
					pair_id <= 10'(k_q);
					pair_edges <= found_q ? inc24(rc_q) : 24'd1;
					st_q <= S_FIN;
				end
				S_PRD: st_q <= S_PRD2;
				S_PRD2: begin
					pair_id <= cmd_q.idx;
					if (32'(cmd_q.idx) < 32'(used_q) && 32'(cmd_q.idx) < PAIR_SLOTS) begin
						pair_origin <= rf_q; pair_target <= rt_q; pair_edges <= rc_q;
					end
					st_q <= S_RDA;
				end
				S_FIN: st_q <= S_OUT; // reread totals of comm_a
				S_OUT: begin
					if (!out_valid) begin
						members <= r_mc; total_in <= r_in; total_out <= r_out;
						cross_out <= r_lv; cross_in <= r_en;
						out_valid <= 1'b1;
					end else if (out_ready) begin
						out_valid <= 1'b0; st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

endmodule

### hdl/community_pair_edge_aggregator.sv
// Contracted community graph builder. Every transaction yields one result.
// The back end works on one transaction at a time, and the pair lookup of a
// counted edge scans the pair list one slot at a time through the single
// pair memory port, so its duration grows with the allocated pair slots.
// Accepted inputs pass through the queue registers before the back end sees them.
// A two-entry queue lets new transactions land while the back end works.
// No clearing pass after reset: community totals carry per-entry valid bits.
module community_pair_edge_aggregator
	import cpea_pkg::*;
#(
	parameter int COMMUNITIES = 256,
	parameter int PAIR_SLOTS  = 1024,
	parameter int DEGREE_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [7:0]  comm_a,
	input  logic [7:0]  comm_b,
	input  logic [15:0] in_degree,
	input  logic [15:0] out_degree,
	input  logic [9:0]  pair_index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [9:0]  pair_id,
	output logic [7:0]  pair_origin,
	output logic [7:0]  pair_target,
	output logic [23:0] pair_edges,
	output logic        is_new,
	output logic        skipped,
	output logic        table_full,
	output logic [23:0] members,
	output logic [31:0] total_in,
	output logic [31:0] total_out,
	output logic [23:0] cross_out,
	output logic [23:0] cross_in
);
	logic q_valid, q_ready;
	cmd_t q_cmd;

	cpea_front #(.COMMUNITIES(COMMUNITIES), .DEGREE_BITS(DEGREE_BITS)) u_front (
		.clk, .arst_n, .in_valid, .in_ready, .op, .comm_a, .comm_b, .in_degree,
		.out_degree, .pair_index, .q_valid, .q_ready, .q_cmd
	);

	cpea_back #(.PAIR_SLOTS(PAIR_SLOTS)) u_back (
		.clk, .arst_n, .q_valid, .q_ready, .q_cmd, .out_valid, .out_ready,
		.pair_id, .pair_origin, .pair_target, .pair_edges, .is_new, .skipped,
		.table_full, .members, .total_in, .total_out, .cross_out, .cross_in
	);

	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $countones({is_new, skipped, table_full}) <= 1)
		else $error("conflicting edge flags");
	a_new_edges: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && is_new) |-> pair_edges == 24'd1)
		else $error("new pair edge count");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid && $stable(pair_id))
		else $error("result dropped");
endmodule

### dv/tb_community_pair_edge_aggregator.sv
module tb_community_pair_edge_aggregator
	import cpea_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NCOMM = 256;
	localparam int NSLOT = 1024;
	localparam int RAND_ITEMS = 450;
	localparam int STALL_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 40;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  op;
	logic [7:0]  comm_a;
	logic [7:0]  comm_b;
	logic [15:0] in_degree;
	logic [15:0] out_degree;
	logic [9:0]  pair_index;
	logic        out_valid;
	logic        out_ready;
	logic [9:0]  pair_id;
	logic [7:0]  pair_origin;
	logic [7:0]  pair_target;
	logic [23:0] pair_edges;
	logic        is_new;
	logic        skipped;
	logic        table_full;
	logic [23:0] members;
	logic [31:0] total_in;
	logic [31:0] total_out;
	logic [23:0] cross_out;
	logic [23:0] cross_in;

	typedef struct packed {
		logic [9:0]  pid;
		logic [7:0]  porg;
		logic [7:0]  ptar;
		logic [23:0] pedges;
		logic        fresh;
		logic        skip;
		logic        full;
		logic [23:0] mem;
		logic [31:0] tin;
		logic [31:0] tout;
		logic [23:0] xout;
		logic [23:0] xin;
	} summary_t;

	// directed row: command plus optional typed-in result
	typedef struct {
		cmd_t     cmd;
		bit       typed;
		summary_t want;
	} row_t;

	community_pair_edge_aggregator u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.op(op), .comm_a(comm_a), .comm_b(comm_b),
		.in_degree(in_degree), .out_degree(out_degree), .pair_index(pair_index),
		.out_valid(out_valid), .out_ready(out_ready),
		.pair_id(pair_id), .pair_origin(pair_origin), .pair_target(pair_target),
		.pair_edges(pair_edges), .is_new(is_new), .skipped(skipped),
		.table_full(table_full), .members(members), .total_in(total_in),
		.total_out(total_out), .cross_out(cross_out), .cross_in(cross_in)
	);

	// shadow of the contracted graph
	logic [23:0] g_members [NCOMM];
	logic [31:0] g_in      [NCOMM];
	logic [31:0] g_out     [NCOMM];
	logic [23:0] g_xout    [NCOMM];
	logic [23:0] g_xin     [NCOMM];
	logic [7:0]  g_from    [NSLOT];
	logic [7:0]  g_to      [NSLOT];
	logic [23:0] g_cnt     [NSLOT];
	int          g_used;

	summary_t pending_q[$];
	int  errors;
	int  quiet_cycles;
	int  send_idle_pct;
	int  recv_idle_pct;
	logic [7:0] hot_comm[8];

	function automatic logic [23:0] inc24(logic [23:0] v);
		return (v == 24'hFFFFFF) ? v : v + 24'd1;
	endfunction

	function automatic logic [31:0] add32(logic [31:0] a, logic [15:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {17'd0, b};
		return s[32] ? 32'hFFFFFFFF : s[31:0];
	endfunction

	function automatic summary_t contract(cmd_t c);
		summary_t r;
		int hit;
		r = '0;
		hit = -1;
		case (c.op)
			OP_VERTEX: begin
				g_members[c.ca] = inc24(g_members[c.ca]);
				g_in[c.ca] = add32(g_in[c.ca], c.in_deg);
				g_out[c.ca] = add32(g_out[c.ca], c.out_deg);
			end
			OP_EDGE: begin
				if (c.ca == c.cb) begin
					r.skip = 1'b1;
				end else begin
					g_xout[c.ca] = inc24(g_xout[c.ca]);
					g_xin[c.cb] = inc24(g_xin[c.cb]);
					r.porg = c.ca;
					r.ptar = c.cb;
					for (int k = 0; k < g_used; k++)
						if (hit < 0 && g_from[k] == c.ca && g_to[k] == c.cb)
							hit = k;
					if (hit < 0 && g_used >= NSLOT) begin
						r.full = 1'b1;
					end else begin
						if (hit < 0) begin
							hit = g_used;
							g_from[hit] = c.ca;
							g_to[hit] = c.cb;
							g_cnt[hit] = '0;
							g_used++;
							r.fresh = 1'b1;
						end
						g_cnt[hit] = inc24(g_cnt[hit]);
						r.pid = hit[9:0];
						r.pedges = g_cnt[hit];
					end
				end
			end
			OP_PAIR: begin
				r.pid = c.idx;
				if (c.idx < g_used) begin
					r.porg = g_from[c.idx];
					r.ptar = g_to[c.idx];
					r.pedges = g_cnt[c.idx];
				end
			end
			default: ;
		endcase
		r.mem = g_members[c.ca];
		r.tin = g_in[c.ca];
		r.tout = g_out[c.ca];
		r.xout = g_xout[c.ca];
		r.xin = g_xin[c.ca];
		return r;
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic send(cmd_t c, bit typed, summary_t want);
		summary_t p;
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= c.op;
		comm_a <= c.ca;
		comm_b <= c.cb;
		in_degree <= c.in_deg;
		out_degree <= c.out_deg;
		pair_index <= c.idx;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		p = contract(c);
		pending_q.push_back(typed ? want : p);
	endtask

	function automatic cmd_t any_cmd();
		cmd_t c;
		c = '0;
		c.op = 2'($urandom_range(3));
		c.ca = ($urandom_range(3) == 0) ? 8'($urandom) : hot_comm[$urandom_range(7)];
		c.cb = ($urandom_range(3) == 0) ? 8'($urandom) : hot_comm[$urandom_range(7)];
		c.in_deg = ($urandom_range(9) == 0) ? 16'hFFFF : 16'($urandom);
		c.out_deg = ($urandom_range(9) == 0) ? 16'hFFFF : 16'($urandom);
		// unwritten pair slots read as zero here, so any index is fine
		c.idx = ($urandom_range(1) == 0) ? 10'($urandom_range(g_used + 3)) : 10'($urandom);
		return c;
	endfunction

	// receiver
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_q.size() == 0) begin
					$error("result with nothing expected");
					errors++;
				end else begin
					summary_t e;
					e = pending_q.pop_front();
					if (pair_id !== e.pid) begin
						$error("pair_id exp %0d got %0d", e.pid, pair_id); errors++;
					end
					if (pair_origin !== e.porg) begin
						$error("pair_origin exp %0d got %0d", e.porg, pair_origin); errors++;
					end
					if (pair_target !== e.ptar) begin
						$error("pair_target exp %0d got %0d", e.ptar, pair_target); errors++;
					end
					if (pair_edges !== e.pedges) begin
						$error("pair_edges exp %0d got %0d", e.pedges, pair_edges); errors++;
					end
					if (is_new !== e.fresh) begin
						$error("is_new exp %0d got %0d", e.fresh, is_new); errors++;
					end
					if (skipped !== e.skip) begin
						$error("skipped exp %0d got %0d", e.skip, skipped); errors++;
					end
					if (table_full !== e.full) begin
						$error("table_full exp %0d got %0d", e.full, table_full); errors++;
					end
					if (members !== e.mem) begin
						$error("members exp %0d got %0d", e.mem, members); errors++;
					end
					if (total_in !== e.tin) begin
						$error("total_in exp %0d got %0d", e.tin, total_in); errors++;
					end
					if (total_out !== e.tout) begin
						$error("total_out exp %0d got %0d", e.tout, total_out); errors++;
					end
					if (cross_out !== e.xout) begin
						$error("cross_out exp %0d got %0d", e.xout, cross_out); errors++;
					end
					if (cross_in !== e.xin) begin
						$error("cross_in exp %0d got %0d", e.xin, cross_in); errors++;
					end
				end
			end
			out_ready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
		end else begin
			out_ready <= 1'b0;
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > STALL_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic cmd_t mk(logic [1:0] o, logic [7:0] a, logic [7:0] b,
			logic [15:0] di, logic [15:0] dq, logic [9:0] x);
		cmd_t c;
		c.op = o; c.ca = a; c.cb = b; c.in_deg = di; c.out_deg = dq; c.idx = x;
		return c;
	endfunction

	function automatic summary_t res(logic [9:0] pid, logic [7:0] po, logic [7:0] pt,
			logic [23:0] pe, logic f, logic s, logic [23:0] m, logic [31:0] ti,
			logic [31:0] to_, logic [23:0] xo, logic [23:0] xi);
		summary_t r;
		r = '0;
		r.pid = pid; r.porg = po; r.ptar = pt; r.pedges = pe; r.fresh = f; r.skip = s;
		r.mem = m; r.tin = ti; r.tout = to_; r.xout = xo; r.xin = xi;
		return r;
	endfunction

	initial begin
		row_t rows[$];
		cmd_t c;
		int phase;

		send_idle_pct = 0;
		recv_idle_pct = 0;
		g_used = 0;
		for (int i = 0; i < NCOMM; i++) begin
			g_members[i] = '0; g_in[i] = '0; g_out[i] = '0; g_xout[i] = '0; g_xin[i] = '0;
		end
		for (int i = 0; i < NSLOT; i++) begin
			g_from[i] = '0; g_to[i] = '0; g_cnt[i] = '0;
		end
		for (int i = 0; i < 8; i++) hot_comm[i] = 8'($urandom);
		hot_comm[0] = 8'd0;
		hot_comm[1] = 8'd255;

		arst_n = 1'b0;
		in_valid = 1'b0;
		op = OP_VERTEX;
		comm_a = '0; comm_b = '0; in_degree = '0; out_degree = '0; pair_index = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		rows.push_back('{mk(OP_COMM, 8'd255, 8'd0, 16'd0, 16'd0, 10'd0), 1,
			res(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0)});
		rows.push_back('{mk(OP_PAIR, 8'd0, 8'd0, 16'd0, 16'd0, 10'd1023), 1,
			res(10'd1023, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0)});
		rows.push_back('{mk(OP_VERTEX, 8'd0, 8'd0, 16'hFFFF, 16'hFFFF, 10'd0), 1,
			res(0, 0, 0, 0, 0, 0, 24'd1, 32'hFFFF, 32'hFFFF, 0, 0)});
		rows.push_back('{mk(OP_VERTEX, 8'd255, 8'd255, 16'd0, 16'd0, 10'h3FF), 1,
			res(0, 0, 0, 0, 0, 0, 24'd1, 0, 0, 0, 0)});
		rows.push_back('{mk(OP_EDGE, 8'd7, 8'd7, 16'd0, 16'd0, 10'd0), 1,
			res(0, 0, 0, 0, 0, 1'b1, 0, 0, 0, 0, 0)});
		rows.push_back('{mk(OP_EDGE, 8'd0, 8'd255, 16'd0, 16'd0, 10'd0), 1,
			res(0, 8'd0, 8'd255, 24'd1, 1'b1, 0, 24'd1, 32'hFFFF, 32'hFFFF, 24'd1, 0)});
		rows.push_back('{mk(OP_EDGE, 8'd0, 8'd255, 16'd0, 16'd0, 10'd0), 0, '0});
		rows.push_back('{mk(OP_EDGE, 8'd255, 8'd0, 16'd0, 16'd0, 10'd0), 0, '0});
		rows.push_back('{mk(OP_EDGE, 8'hAA, 8'h55, 16'hAAAA, 16'h5555, 10'h2AA), 0, '0});
		rows.push_back('{mk(OP_PAIR, 8'd0, 8'd0, 16'd0, 16'd0, 10'd0), 0, '0});
		rows.push_back('{mk(OP_PAIR, 8'd0, 8'd0, 16'd0, 16'd0, 10'd2), 0, '0});
		rows.push_back('{mk(OP_PAIR, 8'd0, 8'd0, 16'd0, 16'd0, 10'd3), 0, '0});
		rows.push_back('{mk(OP_COMM, 8'd0, 8'd0, 16'd0, 16'd0, 10'd0), 0, '0});
		rows.push_back('{mk(OP_COMM, 8'd255, 8'd0, 16'd0, 16'd0, 10'd0), 0, '0});
		rows.push_back('{mk(OP_VERTEX, 8'h55, 8'hAA, 16'h5555, 16'hAAAA, 10'h155), 0, '0});
		// add repeated full-scale in-degrees to the in-degree sum of one community
		for (int i = 0; i < 8; i++)
			rows.push_back('{mk(OP_VERTEX, 8'd3, 8'd0, 16'hFFFF, 16'h8000, 10'd0), 0, '0});
		rows.push_back('{mk(OP_COMM, 8'd3, 8'd0, 16'd0, 16'd0, 10'd0), 0, '0});

		recv_idle_pct = 62;
		foreach (rows[i]) send(rows[i].cmd, rows[i].typed, rows[i].want);
		in_valid <= 1'b0;

		// hold off until every result is back
		while (pending_q.size() != 0) @(posedge clk);

		for (phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 6 : (phase == 1) ? 62 : 0;
			recv_idle_pct = (phase == 0) ? 62 : (phase == 1) ? 6 : 0;
			for (int n = 0; n < RAND_ITEMS / 3; n++) begin
				c = any_cmd();
				// mostly edges among a few hot communities so pairs repeat
				if ($urandom_range(9) < 5) c.op = OP_EDGE;
				send(c, 0, '0);
			end
		end
		in_valid <= 1'b0;

		while (pending_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
